### rtl/core/olr_pkg.sv
// ---------------------------------------------------------------------------
// olr_pkg - shared types for the overwriting log ring
// Command codes and the request and response word layouts.
// ---------------------------------------------------------------------------
package olr_pkg;

   // default number of ring slots (ring holds at most DEPTH-1 bytes)
   localparam int unsigned DEFAULT_DEPTH = 1024;

   typedef enum logic [1:0] {
      CMD_PUT    = 2'd0,
      CMD_TAKE   = 2'd1,
      CMD_PEEK   = 2'd2,
      CMD_REWIND = 2'd3
   } cmd_type;

   // request word
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] byte_in;
   } req_type;

   // response word
   typedef struct packed {
      logic [7:0] byte_out;
      logic       byte_valid;
      logic       dropped_oldest;
      logic       ring_empty;
      logic       cursor_at_end;
   } rsp_type;

endpackage

### rtl/core/overwrite_log_ring_with_cursor.sv
// ---------------------------------------------------------------------------
// overwrite_log_ring_with_cursor - byte log ring with overwrite and cursor
// Puts append (dropping the oldest byte when full), takes pop the oldest
// byte, peeks walk a viewing cursor, rewind moves the cursor to the oldest.
// ---------------------------------------------------------------------------
// Response path: read data and read-stage flags register when a request word
//   is accepted; the response register loads them once it is free.
// Throughput: one word per cycle while responses are taken; each command
//   either writes or reads the single memory port. A stalled response
//   holds two words, then req_ready drops.
// Reset: clears the write, oldest and view pointers and the pipeline valids;
//   the log memory is not cleared and needs no clearing pass.
module overwrite_log_ring_with_cursor #(
   parameter int unsigned DEPTH = olr_pkg::DEFAULT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  olr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output olr_pkg::rsp_type rsp_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   // ring pointers
   logic [PTR_W-1:0] write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0] oldest_ptr_ff, oldest_ptr_in;
   logic [PTR_W-1:0] view_ptr_ff, view_ptr_in;

   // memory read stage
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_byte_valid_ff, s1_byte_valid_in;
   logic             s1_dropped_ff, s1_dropped_in;
   logic             s1_empty_ff, s1_empty_in;
   logic             s1_at_end_ff, s1_at_end_in;
   logic [7:0]       rd_data_ff;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   olr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [7:0]       log_mem [DEPTH];

   logic             req_fire;
   logic             out_load;
   logic             wr_en;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic [PTR_W-1:0] wr_next;
   logic [PTR_W-1:0] oldest_next;
   logic [PTR_W-1:0] view_next;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
   endfunction

   // handshake and pipeline advance
   assign out_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign req_fire  = req_valid && req_ready;

   assign wr_next     = ring_next(write_ptr_ff);
   assign oldest_next = ring_next(oldest_ptr_ff);
   assign view_next   = ring_next(view_ptr_ff);

   // command decode and pointer update
   always_comb begin
      write_ptr_in     = write_ptr_ff;
      oldest_ptr_in    = oldest_ptr_ff;
      view_ptr_in      = view_ptr_ff;
      s1_byte_valid_in = 1'b0;
      s1_dropped_in    = 1'b0;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      rd_addr          = oldest_ptr_ff;
      if (req_fire) begin
         case (req_data.cmd)
            olr_pkg::CMD_PUT: begin
               wr_en = 1'b1;
               write_ptr_in = wr_next;
               if (wr_next == oldest_ptr_ff) begin
                  // full: drop oldest, cursor follows if it sat there
                  oldest_ptr_in = oldest_next;
                  s1_dropped_in = 1'b1;
                  if (view_ptr_ff == oldest_ptr_ff) begin
                     view_ptr_in = oldest_next;
                  end
               end
            end
            olr_pkg::CMD_TAKE: begin
               if (oldest_ptr_ff != write_ptr_ff) begin
                  rd_en = 1'b1;
                  rd_addr = oldest_ptr_ff;
                  s1_byte_valid_in = 1'b1;
                  oldest_ptr_in = oldest_next;
               end
            end
            olr_pkg::CMD_PEEK: begin
               if (view_ptr_ff != write_ptr_ff) begin
                  rd_en = 1'b1;
                  rd_addr = view_ptr_ff;
                  s1_byte_valid_in = 1'b1;
                  view_ptr_in = view_next;
               end
            end
            olr_pkg::CMD_REWIND: begin
               view_ptr_in = oldest_ptr_ff;
            end
            default: begin
               view_ptr_in = view_ptr_ff;
            end
         endcase
      end
      s1_empty_in  = (oldest_ptr_in == write_ptr_in);
      s1_at_end_in = (view_ptr_in == write_ptr_in);
      s1_valid_in  = req_fire ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
   end

   // response register next value
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.byte_out       = s1_byte_valid_ff ? rd_data_ff : 8'd0;
         rsp_data_in.byte_valid     = s1_byte_valid_ff;
         rsp_data_in.dropped_oldest = s1_dropped_ff;
         rsp_data_in.ring_empty     = s1_empty_ff;
         rsp_data_in.cursor_at_end  = s1_at_end_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // log memory: one write or one read per cycle, registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         log_mem[write_ptr_ff] <= req_data.byte_in;
      end
      if (rd_en) begin
         rd_data_ff <= log_mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff  <= '0;
         oldest_ptr_ff <= '0;
         view_ptr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         write_ptr_ff  <= write_ptr_in;
         oldest_ptr_ff <= oldest_ptr_in;
         view_ptr_ff   <= view_ptr_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_valid_ff <= s1_byte_valid_in;
         s1_dropped_ff    <= s1_dropped_in;
         s1_empty_ff      <= s1_empty_in;
         s1_at_end_ff     <= s1_at_end_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- assertions ----

   // a put always leaves at least one byte in the ring
   a_put_not_empty: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.cmd == olr_pkg::CMD_PUT |=> oldest_ptr_ff != write_ptr_ff)
      else $error("ring empty after put");

   // read data held while the read stage waits on the response register
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_load |=> $stable(rd_data_ff))
      else $error("read data lost while stalled");

   // the memory port never reads and writes in one cycle
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("memory read and write collide");

   // a response never both returns a byte and reports a drop
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.byte_valid && rsp_data_ff.dropped_oldest))
      else $error("byte and drop in one word");

   // pointers stay inside the ring
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      write_ptr_ff <= LAST_SLOT && oldest_ptr_ff <= LAST_SLOT && view_ptr_ff <= LAST_SLOT)
      else $error("pointer beyond last slot");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for the overwriting log ring
// Drives put, take, peek and rewind words through the request channel with
// random idle gaps. A shadow copy of the ring predicts every response word.
// The sink checks each response against the oldest prediction. Tests cover
// empty and end-of-log cases, a stale cursor, overwrite with cursor carry
// and a long response stall that backs up the request channel.
// ---------------------------------------------------------------------------
module tb_top;
   import olr_pkg::*;

   localparam int unsigned DEPTH = DEFAULT_DEPTH;
   localparam int unsigned PW = $clog2(DEPTH);
   localparam int MAX_REPORTS = 10;

   typedef logic [PW-1:0] slot_type;
   typedef enum {MIX_EVEN, MIX_GROW, MIX_DRAIN, MIX_BROWSE} cmd_mix_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow ring state
   logic [7:0] log_bytes [DEPTH];
   slot_type   put_slot = '0;
   slot_type   oldest_slot = '0;
   slot_type   view_slot = '0;

   // predicted response words, oldest first
   rsp_type expected_rsp [$];
   int      fail_count = 0;

   // no_idle drops all gaps on both sides; hold_request asks the sink for a long stall
   bit no_idle = 1'b0;
   int hold_request = 0;

   overwrite_log_ring_with_cursor #(.DEPTH(DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic slot_type next_slot(slot_type p);
      return (p == slot_type'(DEPTH - 1)) ? '0 : slot_type'(p + 1'b1);
   endfunction

   // advance the shadow ring by one word and return its response
   function automatic rsp_type predict_ring_step(req_type w);
      rsp_type r;
      r = '0;
      case (w.cmd)
         CMD_PUT: begin
            // full ring: drop the oldest byte, carry a cursor that sat on it
            if (next_slot(put_slot) == oldest_slot) begin
               if (view_slot == oldest_slot) view_slot = next_slot(oldest_slot);
               oldest_slot = next_slot(oldest_slot);
               r.dropped_oldest = 1'b1;
            end
            log_bytes[put_slot] = w.byte_in;
            put_slot = next_slot(put_slot);
         end
         CMD_TAKE: begin
            if (oldest_slot != put_slot) begin
               r.byte_out = log_bytes[oldest_slot];
               r.byte_valid = 1'b1;
               oldest_slot = next_slot(oldest_slot);
            end
         end
         CMD_PEEK: begin
            // a stale cursor behind the oldest byte still walks its slots
            if (view_slot != put_slot) begin
               r.byte_out = log_bytes[view_slot];
               r.byte_valid = 1'b1;
               view_slot = next_slot(view_slot);
            end
         end
         default: begin
            view_slot = oldest_slot;
         end
      endcase
      r.ring_empty = (oldest_slot == put_slot);
      r.cursor_at_end = (view_slot == put_slot);
      return r;
   endfunction

   // offer one request word after a random gap, predict once accepted
   task automatic send_word(cmd_type cmd, logic [7:0] data);
      int      gap;
      req_type w;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      w.cmd = cmd;
      w.byte_in = data;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected_rsp.push_back(predict_ring_step(w));
   endtask

   function automatic cmd_type pick_cmd(cmd_mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_GROW:   return roll < 70 ? CMD_PUT : roll < 80 ? CMD_TAKE :
                            roll < 95 ? CMD_PEEK : CMD_REWIND;
         MIX_DRAIN:  return roll < 20 ? CMD_PUT : roll < 70 ? CMD_TAKE :
                            roll < 90 ? CMD_PEEK : CMD_REWIND;
         MIX_BROWSE: return roll < 30 ? CMD_PUT : roll < 40 ? CMD_TAKE :
                            roll < 85 ? CMD_PEEK : CMD_REWIND;
         default:    return roll < 40 ? CMD_PUT : roll < 60 ? CMD_TAKE :
                            roll < 90 ? CMD_PEEK : CMD_REWIND;
      endcase
   endfunction

   // response sink: check each word, then draw the next hold-off
   initial begin : rsp_sink
      rsp_type want;
      int      idle_left;
      int      hold_left;
      idle_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected response word %h", rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.byte_out !== want.byte_out ||
                   rsp_data.byte_valid !== want.byte_valid ||
                   rsp_data.dropped_oldest !== want.dropped_oldest ||
                   rsp_data.ring_empty !== want.ring_empty ||
                   rsp_data.cursor_at_end !== want.cursor_at_end) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display({"mismatch: byte_out %h/%h valid %b/%b dropped %b/%b ",
                               "empty %b/%b at_end %b/%b (expected/actual)"},
                              want.byte_out, rsp_data.byte_out,
                              want.byte_valid, rsp_data.byte_valid,
                              want.dropped_oldest, rsp_data.dropped_oldest,
                              want.ring_empty, rsp_data.ring_empty,
                              want.cursor_at_end, rsp_data.cursor_at_end);
               end
            end
            idle_left = no_idle ? 0 : $urandom_range(0, 15);
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // empty ring, end of log, extreme bytes and a stale cursor
   task automatic test_empty_and_cursor();
      send_word(CMD_TAKE, 8'h00);     // take on empty ring
      send_word(CMD_PEEK, 8'hFF);     // peek at end
      send_word(CMD_REWIND, 8'h00);
      send_word(CMD_PUT, 8'h00);
      send_word(CMD_PUT, 8'hFF);
      send_word(CMD_PUT, 8'hA5);
      send_word(CMD_PEEK, 8'h00);
      send_word(CMD_PEEK, 8'h00);
      send_word(CMD_PEEK, 8'h00);
      send_word(CMD_PEEK, 8'h00);     // cursor reached the write pointer
      send_word(CMD_REWIND, 8'hFF);
      send_word(CMD_PEEK, 8'h00);
      // takes move the oldest byte past the cursor
      send_word(CMD_TAKE, 8'h00);
      send_word(CMD_TAKE, 8'h00);
      send_word(CMD_PEEK, 8'h00);
      send_word(CMD_PEEK, 8'h00);
      send_word(CMD_PEEK, 8'h00);
      send_word(CMD_TAKE, 8'h00);
      send_word(CMD_TAKE, 8'h00);
      send_word(CMD_REWIND, 8'h00);
      send_word(CMD_PUT, 8'h5A);
      send_word(CMD_PEEK, 8'h00);
      send_word(CMD_TAKE, 8'h00);
   endtask

   // random words in blocks of one command mix each
   task automatic test_random_mix(int count);
      cmd_mix_type mix;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            mix = cmd_mix_type'($urandom_range(0, 3));
            no_idle = ($urandom_range(0, 5) == 0);
         end
         send_word(pick_cmd(mix), 8'($urandom_range(0, 255)));
      end
      no_idle = 1'b0;
   endtask

   // sink stalls for a long stretch while words keep coming
   task automatic test_output_stall();
      hold_request = 120;
      no_idle = 1'b1;
      for (int i = 0; i < 60; i++)
         send_word(($urandom_range(0, 1) == 0) ? CMD_PUT : CMD_PEEK,
                   8'($urandom_range(0, 255)));
      no_idle = 1'b0;
   endtask

   // fill past capacity with the cursor on the oldest byte, then overwrite
   task automatic test_overwrite_full();
      send_word(CMD_REWIND, 8'h00);
      no_idle = 1'b1;
      for (int i = 0; i < DEPTH + 80; i++)
         send_word(CMD_PUT, 8'($urandom_range(0, 255)));
      no_idle = 1'b0;
      repeat (8) send_word(CMD_PEEK, 8'h00);
      // cursor ahead of the oldest byte: drops leave it alone until they reach it
      repeat (10) send_word(CMD_PUT, 8'($urandom_range(0, 255)));
      send_word(CMD_REWIND, 8'h00);
      // cursor on the oldest byte: carried along
      repeat (6) send_word(CMD_PUT, 8'($urandom_range(0, 255)));
      repeat (4) send_word(CMD_PEEK, 8'h00);
      repeat (4) send_word(CMD_TAKE, 8'h00);
      send_word(CMD_PEEK, 8'h00);
   endtask

   initial begin : run
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_cursor();
      test_random_mix(500);
      test_output_stall();
      test_overwrite_full();
      test_random_mix(150);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### overwrite_log_ring_with_cursor.f
rtl/core/olr_pkg.sv
rtl/core/overwrite_log_ring_with_cursor.sv
tb/tb_top.sv
